// ===== src/tspa_pkg.sv =====
// Shared constants, command codes and controller state type for the timed slot pool.
// No dependencies.
`default_nettype none

package tspa_pkg;

   localparam int SLOTS         = 4096;
   localparam int IDX_W         = 12;   // slot index field width
   localparam int CNT_W         = 13;   // depth and count width (holds SLOTS itself)
   localparam int LIFE_W        = 31;
   localparam int ELAPSED_W     = 16;
   localparam int TIME_BITS_DEF = 32;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_SWEEP = 1'b1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_POP,
      ST_SWEEP,
      ST_FLUSH,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== src/timed_slot_pool_allocator_core.sv =====
// Allocate: a stack read, then a slot write, then the response state when a slot is free;
// straight to the response state when the pool is empty. Sweep: reads the slot RAM one slot
// per cycle, then a flush state, then the response state. One item at a time; the next item
// is taken while a result waits.
// Reset: synchronous; afterwards a clearing pass over all SLOTS entries fills the free stack
// and clears the slot table, with req_ready low.
`default_nettype none

module timed_slot_pool_allocator_core #(
   parameter int TIME_BITS = tspa_pkg::TIME_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_command,
   input  wire logic [tspa_pkg::ELAPSED_W-1:0] req_elapsed_ticks,
   input  wire logic [tspa_pkg::LIFE_W-1:0]    req_lifetime_ticks,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_granted,
   output logic [tspa_pkg::IDX_W-1:0]          rsp_slot_index,
   output logic [tspa_pkg::CNT_W-1:0]          rsp_expired_count,
   output logic [tspa_pkg::CNT_W-1:0]          rsp_free_slots
);
   import tspa_pkg::*;

   localparam int SLOT_W = 1 + TIME_BITS + LIFE_W;
   localparam int CMP_W  = (TIME_BITS > LIFE_W) ? TIME_BITS : LIFE_W;

   state_type state_ff, state_in;

   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [CNT_W-1:0]     depth_ff, depth_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic                 eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]     eval_idx_ff, eval_idx_in;
   logic [LIFE_W-1:0]    life_ff, life_in;
   logic                 pend_grant_ff, pend_grant_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_granted_ff;
   logic [IDX_W-1:0]     rsp_idx_ff;
   logic [CNT_W-1:0]     rsp_cnt_ff;
   logic [CNT_W-1:0]     rsp_free_ff;
   logic                 rsp_load;

   // memory ports
   logic                 slot_we;
   logic [IDX_W-1:0]     slot_wa;
   logic [SLOT_W-1:0]    slot_wd;
   logic [SLOT_W-1:0]    slot_rd;
   logic                 stk_we;
   logic [IDX_W-1:0]     stk_wa;
   logic [IDX_W-1:0]     stk_wd;
   logic [IDX_W-1:0]     stk_ra;
   logic [IDX_W-1:0]     stk_rd;

   // sweep evaluation of the slot word that arrived this cycle
   logic                 ev_valid;
   logic [TIME_BITS-1:0] ev_birth;
   logic [LIFE_W-1:0]    ev_life;
   logic [TIME_BITS-1:0] ev_age;
   logic                 ev_expire;
   logic [CNT_W-1:0]     depth_dec;
   logic                 accept;

   tspa_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wa),
      .wr_data (slot_wd),
      .rd_addr (scan_ff),
      .rd_data (slot_rd)
   );

   tspa_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   assign ev_valid  = slot_rd[SLOT_W-1];
   assign ev_birth  = slot_rd[LIFE_W +: TIME_BITS];
   assign ev_life   = slot_rd[LIFE_W-1:0];
   assign ev_age    = now_ff - ev_birth;
   assign ev_expire = eval_vld_ff && ev_valid && (CMP_W'(ev_age) > CMP_W'(ev_life));
   assign depth_dec = depth_ff - 1'b1;
   assign stk_ra    = depth_dec[IDX_W-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      depth_in      = depth_ff;
      cnt_in        = cnt_ff;
      scan_in       = scan_ff;
      eval_vld_in   = 1'b0;
      eval_idx_in   = scan_ff;
      life_in       = life_ff;
      pend_grant_in = pend_grant_ff;
      pend_idx_in   = pend_idx_ff;
      slot_we       = 1'b0;
      slot_wa       = scan_ff;
      slot_wd       = '0;
      stk_we        = 1'b0;
      stk_wa        = scan_ff;
      stk_wd        = scan_ff;

      // expiry from the previous sweep read; the write trails the read by one slot
      if (ev_expire) begin
         slot_we = 1'b1;
         slot_wa = eval_idx_ff;
         slot_wd = '0;
         cnt_in  = cnt_ff + 1'b1;
         if (depth_ff < CNT_W'(SLOTS)) begin
            stk_we   = 1'b1;
            stk_wa   = depth_ff[IDX_W-1:0];
            stk_wd   = eval_idx_ff;
            depth_in = depth_ff + 1'b1;
         end
      end

      case (state_ff)
         ST_INIT: begin
            slot_we = 1'b1;
            slot_wa = scan_ff;
            slot_wd = '0;
            stk_we  = 1'b1;
            stk_wa  = scan_ff;
            stk_wd  = scan_ff;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == IDX_W'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cnt_in        = '0;
               pend_grant_in = 1'b0;
               pend_idx_in   = '0;
               life_in       = req_lifetime_ticks;
               if (req_command == CMD_SWEEP) begin
                  now_in   = now_ff + TIME_BITS'(req_elapsed_ticks);
                  scan_in  = '0;
                  state_in = ST_SWEEP;
               end else if (depth_ff == '0) begin
                  state_in = ST_RESP;
               end else begin
                  depth_in = depth_dec;
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            slot_we       = 1'b1;
            slot_wa       = stk_rd;
            slot_wd       = {1'b1, now_ff, life_ff};
            pend_grant_in = 1'b1;
            pend_idx_in   = stk_rd;
            state_in      = ST_RESP;
         end
         ST_SWEEP: begin
            eval_vld_in = 1'b1;
            eval_idx_in = scan_ff;
            scan_in     = scan_ff + 1'b1;
            if (scan_ff == IDX_W'(SLOTS - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // last slot is evaluated this cycle
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         now_ff       <= '0;
         depth_ff     <= CNT_W'(SLOTS);
         scan_ff      <= '0;
         eval_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         depth_ff     <= depth_in;
         scan_ff      <= scan_in;
         eval_vld_ff  <= eval_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      eval_idx_ff   <= eval_idx_in;
      life_ff       <= life_in;
      pend_grant_ff <= pend_grant_in;
      pend_idx_ff   <= pend_idx_in;
      if (rsp_load) begin
         rsp_granted_ff <= pend_grant_ff;
         rsp_idx_ff     <= pend_idx_ff;
         rsp_cnt_ff     <= cnt_ff;
         rsp_free_ff    <= depth_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_slot_index    = rsp_idx_ff;
   assign rsp_expired_count = rsp_cnt_ff;
   assign rsp_free_slots    = rsp_free_ff;

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CNT_W'(SLOTS))
      else $error("free depth above pool size");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second beat taken while busy");

   a_pop_depth: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_ALLOC && depth_ff != '0)
      |=> depth_ff == $past(depth_dec))
      else $error("allocate did not pop the free stack");

   a_eval_in_sweep: assert property (@(posedge clock) disable iff (reset)
      eval_vld_ff |-> (state_ff == ST_SWEEP || state_ff == ST_FLUSH))
      else $error("slot evaluation outside a sweep");
`endif

endmodule

`default_nettype wire

// ===== src/tspa_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module tspa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
